// ===== sv/lfs_pkg.sv =====
// Shared types, widths, register codes and reset values for the line follower.
`timescale 1ns / 1ps

package lfs_pkg;

    localparam int MAX_ROW_WIDTH = 4096;

    localparam int LUM_W    = 8;
    localparam int COL_W    = 12;
    localparam int HALF_W   = 12;
    localparam int ROW_W    = 13;
    localparam int WEIGHT_W = 10;
    localparam int POS_W    = COL_W + WEIGHT_W;
    localparam int TERM_W   = POS_W + 2;
    localparam int ERR_W    = 32;
    localparam int BASE_W   = 10;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = ERR_W + GAIN_W;
    localparam int FRAC_W   = 24;
    localparam int DIFF_W   = PROD_W + 2;
    localparam int SPEED_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = ERR_W + 2 * SPEED_W;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LUM_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_WEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 3'd5;

    localparam logic [BASE_W-1:0]   RST_BASE_SPEED    = 10'd10;
    localparam logic [GAIN_W-1:0]   RST_STEER_GAIN    = 16'd1966;
    localparam logic [LUM_W-1:0]    RST_LUM_THRESHOLD = 8'd250;
    localparam logic [WEIGHT_W-1:0] RST_RIGHT_WEIGHT  = 10'd282;
    localparam logic [WEIGHT_W-1:0] RST_LEFT_WEIGHT   = 10'd230;
    localparam logic [ROW_W-1:0]    RST_ROW_WIDTH     = 13'd320;

    typedef struct packed {
        logic [BASE_W-1:0]   base_speed;
        logic [GAIN_W-1:0]   steer_gain;
        logic [LUM_W-1:0]    lum_threshold;
        logic [WEIGHT_W-1:0] right_weight;
        logic [WEIGHT_W-1:0] left_weight;
        logic [ROW_W-1:0]    row_width;
    } cfg_t;

endpackage

// ===== sv/lfs_cfg_regs.sv =====
// Configuration register file of the line follower.
`timescale 1ns / 1ps

module lfs_cfg_regs
    import lfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BASE_SPEED:    cfg_next.base_speed    = cfg_data[BASE_W-1:0];
                REG_STEER_GAIN:    cfg_next.steer_gain    = cfg_data[GAIN_W-1:0];
                REG_LUM_THRESHOLD: cfg_next.lum_threshold = cfg_data[LUM_W-1:0];
                REG_RIGHT_WEIGHT:  cfg_next.right_weight  = cfg_data[WEIGHT_W-1:0];
                REG_LEFT_WEIGHT:   cfg_next.left_weight   = cfg_data[WEIGHT_W-1:0];
                REG_ROW_WIDTH:     cfg_next.row_width     = cfg_data[ROW_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_speed    <= RST_BASE_SPEED;
            cfg_reg.steer_gain    <= RST_STEER_GAIN;
            cfg_reg.lum_threshold <= RST_LUM_THRESHOLD;
            cfg_reg.right_weight  <= RST_RIGHT_WEIGHT;
            cfg_reg.left_weight   <= RST_LEFT_WEIGHT;
            cfg_reg.row_width     <= RST_ROW_WIDTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/lfs_accum.sv =====
// Pixel path: input register, weighted position term, and saturating row sum.
`timescale 1ns / 1ps

module lfs_accum
    import lfs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_DATA_W-1:0]     s_tdata,
    input  logic                    s_tlast,
    input  logic                    res_ready,
    output logic                    res_valid,
    output logic signed [ERR_W-1:0] res_error
);

    // Input stage.
    logic              in_valid_reg, in_valid_next;
    logic [LUM_W-1:0]  in_lum_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic              in_last_reg;
    logic [COL_W-1:0]  col_reg, col_next;

    // Term stage.
    logic                     tm_valid_reg, tm_valid_next;
    logic                     tm_last_reg;
    logic signed [TERM_W-1:0] tm_term_reg, tm_term_next;

    // Row sum and finished error.
    logic signed [ERR_W-1:0] sum_reg, sum_next;
    logic                    e_valid_reg, e_valid_next;
    logic signed [ERR_W-1:0] e_value_reg;

    logic s_accept, in_adv, tm_adv, tm_free, e_free;
    logic [ROW_W-1:0]    width_clamped;
    logic [HALF_W-1:0]   half;
    logic [WEIGHT_W-1:0] weight;
    logic [POS_W-1:0]    pos;
    logic                hit;
    logic signed [ERR_W:0]   wide_sum;
    logic signed [ERR_W-1:0] sat_sum;

    // Backpressure only reaches the pixel side when a row end meets a full result path.
    assign e_free   = !e_valid_reg || res_ready;
    assign tm_adv   = tm_valid_reg && (!tm_last_reg || e_free);
    assign tm_free  = !tm_valid_reg || tm_adv;
    assign in_adv   = in_valid_reg && tm_free;
    assign s_tready = !in_valid_reg || tm_free;
    assign s_accept = s_tvalid && s_tready;

    assign res_valid = e_valid_reg;
    assign res_error = e_value_reg;

    always_comb begin
        if (cfg.row_width < ROW_W'(2)) begin
            width_clamped = ROW_W'(2);
        end else if (cfg.row_width > ROW_W'(MAX_ROW_WIDTH)) begin
            width_clamped = ROW_W'(MAX_ROW_WIDTH);
        end else begin
            width_clamped = cfg.row_width;
        end
        half   = width_clamped[ROW_W-1:1];
        hit    = (in_lum_reg > cfg.lum_threshold) && (in_col_reg != half);
        weight = (in_col_reg > half) ? cfg.right_weight : cfg.left_weight;
        pos    = POS_W'(in_col_reg) * POS_W'(weight);
        if (hit) begin
            tm_term_next = $signed({2'b00, pos}) - $signed({4'b0000, half, 8'h00});
        end else begin
            tm_term_next = '0;
        end
    end

    always_comb begin
        wide_sum = {sum_reg[ERR_W-1], sum_reg}
                 + {{(ERR_W + 1 - TERM_W){tm_term_reg[TERM_W-1]}}, tm_term_reg};
        if (wide_sum[ERR_W] != wide_sum[ERR_W-1]) begin
            sat_sum = wide_sum[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        end else begin
            sat_sum = wide_sum[ERR_W-1:0];
        end
    end

    always_comb begin
        col_next = col_reg;
        if (s_accept) begin
            if (s_tlast) begin
                col_next = '0;
            end else if (col_reg != {COL_W{1'b1}}) begin
                col_next = col_reg + COL_W'(1);
            end
        end
        in_valid_next = s_accept || (in_valid_reg && !in_adv);
        tm_valid_next = in_adv || (tm_valid_reg && !tm_adv);
        e_valid_next  = (tm_adv && tm_last_reg) || (e_valid_reg && !res_ready);
        sum_next      = sum_reg;
        if (tm_adv) begin
            sum_next = tm_last_reg ? '0 : sat_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            tm_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
            col_reg      <= '0;
            sum_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            tm_valid_reg <= tm_valid_next;
            e_valid_reg  <= e_valid_next;
            col_reg      <= col_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_lum_reg  <= s_tdata[LUM_W-1:0];
            in_col_reg  <= col_reg;
            in_last_reg <= s_tlast;
        end
        if (in_adv) begin
            tm_term_reg <= tm_term_next;
            tm_last_reg <= in_last_reg;
        end
        if (tm_adv && tm_last_reg) begin
            e_value_reg <= sat_sum;
        end
    end

`ifndef NO_ASSERTIONS
    // A row end leaves a clean sum for the next row.
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        tm_adv && tm_last_reg |=> sum_reg == '0)
        else $error("row sum not cleared after row end");

    // The column counter restarts after an accepted row end.
    a_col_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> col_reg == '0)
        else $error("column counter not restarted after row end");

    // A finished error waiting on the speed path is neither lost nor changed.
    a_err_held: assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg && !res_ready |=> e_valid_reg && $stable(e_value_reg))
        else $error("pending row error lost or changed");
`endif

endmodule

// ===== sv/lfs_speed.sv =====
// Speed path: error magnitude times gain, then Q24 truncation and saturation.
`timescale 1ns / 1ps

module lfs_speed
    import lfs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    res_valid,
    output logic                    res_ready,
    input  logic signed [ERR_W-1:0] res_error,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_W-1:0]     m_tdata
);

    logic                    p_valid_reg, p_valid_next;
    logic signed [ERR_W-1:0] p_err_reg;
    logic [PROD_W-1:0]       p_prod_reg, p_prod_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;

    logic out_free, p_free;
    logic [ERR_W-1:0]         mag;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        abs_diff;
    logic [DIFF_W-FRAC_W-1:0] q_mag;
    logic                     diff_neg;
    logic signed [SPEED_W-1:0] reduced, base16, left_spd, right_spd;

    assign out_free  = !m_valid_reg || m_tready;
    assign p_free    = !p_valid_reg || out_free;
    assign res_ready = p_free;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Magnitude of the most negative error is 2^31, which still fits unsigned.
    always_comb begin
        mag         = res_error[ERR_W-1] ? ERR_W'(-res_error) : res_error;
        p_prod_next = PROD_W'(mag) * PROD_W'(cfg.steer_gain);
    end

    always_comb begin
        base16   = $signed({{(SPEED_W-BASE_W){1'b0}}, cfg.base_speed});
        diff     = $signed({{(DIFF_W-BASE_W-FRAC_W){1'b0}}, cfg.base_speed, {FRAC_W{1'b0}}})
                 - $signed({2'b00, p_prod_reg});
        diff_neg = diff[DIFF_W-1];
        abs_diff = diff_neg ? DIFF_W'(-diff) : diff;
        q_mag    = abs_diff[DIFF_W-1:FRAC_W];
        if (diff_neg) begin
            if (q_mag > (DIFF_W-FRAC_W)'(32768)) begin
                reduced = {1'b1, {(SPEED_W-1){1'b0}}};
            end else begin
                reduced = SPEED_W'(-q_mag);
            end
        end else begin
            if (q_mag > (DIFF_W-FRAC_W)'(32767)) begin
                reduced = {1'b0, {(SPEED_W-1){1'b1}}};
            end else begin
                reduced = q_mag[SPEED_W-1:0];
            end
        end
        priority if (p_err_reg > 0) begin
            left_spd  = base16;
            right_spd = reduced;
        end else if (p_err_reg < 0) begin
            left_spd  = reduced;
            right_spd = base16;
        end else begin
            left_spd  = base16;
            right_spd = base16;
        end
        m_data_next = {right_spd, left_spd, p_err_reg};
    end

    always_comb begin
        p_valid_next = (res_valid && p_free) || (p_valid_reg && !out_free);
        m_valid_next = (p_valid_reg && out_free) || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && p_free) begin
            p_err_reg  <= res_error;
            p_prod_reg <= p_prod_next;
        end
        if (p_valid_reg && out_free) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A centred line drives both motors at the cruising speed.
    a_zero_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[ERR_W-1:0] == '0
        |-> m_data_reg[ERR_W +: SPEED_W] == {{(SPEED_W-BASE_W){1'b0}}, cfg.base_speed}
            && m_data_reg[ERR_W+SPEED_W +: SPEED_W] == m_data_reg[ERR_W +: SPEED_W])
        else $error("zero error but speeds differ from base");

    // Steering never speeds a motor up past the cruising speed.
    a_right_slower: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg[ERR_W-1] && m_data_reg[ERR_W-1:0] != '0
        |-> $signed(m_data_reg[ERR_W+SPEED_W +: SPEED_W])
            <= $signed({{(SPEED_W-BASE_W){1'b0}}, cfg.base_speed}))
        else $error("right speed above base for positive error");

    // A product that may move on always lands in the output register.
    a_prod_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && out_free |=> m_valid_reg)
        else $error("product dropped before output");
`endif

endmodule

// ===== sv/line_follow_steering.sv =====
// Top level of the camera-row line follower with proportional steering.
// Throughput: one pixel item per clock. Pixels stall only when three row results wait on
// a stalled result side and a fourth row end reaches the term stage.
// A result item reaches m_tvalid from its accepted row-end pixel through the input, term,
// error, product and output registers.
// Synchronous active-low reset loads register defaults, clears the row and empties the pipeline.
`timescale 1ns / 1ps

module line_follow_steering
    import lfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Pixel items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,    // [7:0] pixel_lum
    input  logic                  s_tlast,    // row_end
    // Result items, one per row.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,    // [31:0] line_error, [47:32] left_speed,
                                              // [63:48] right_speed
    // Register writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                    cfg;
    logic                    res_valid;
    logic                    res_ready;
    logic signed [ERR_W-1:0] res_error;

    // Register file. Writes are only expected while no row is in flight.
    lfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pixel path: one 12x10 multiply for the term, then one 33-bit saturating add.
    // It keeps taking pixels while finished row errors wait in the speed path; it
    // only stalls when a row end reaches the term stage while three results wait.
    lfs_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_error (res_error)
    );

    // Speed path: one 32x16 multiply, then a 50-bit subtract, truncate and saturate.
    // The reduced speed goes to the right motor for a positive error and to the left
    // motor for a negative one.
    lfs_speed u_speed (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_error (res_error),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/line_follow_steering_checker.sv =====
// Checker for the line follower: tracks register writes and pixel items and scores each result.
`timescale 1ns / 1ps

module line_follow_steering_checker
    import lfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    rows_pending,
    output int                    rows_checked,
    output int                    mismatches
);

    localparam longint ERR_MAX   = 64'sd2147483647;
    localparam longint ERR_MIN   = -64'sd2147483648;
    localparam longint SPEED_MAX = 64'sd32767;
    localparam longint SPEED_MIN = -64'sd32768;

    // Same layout as m_tdata: line_error in the lowest bits.
    typedef struct packed {
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [ERR_W-1:0]   line_error;
    } steer_t;

    cfg_t                    regs;
    logic [COL_W-1:0]        column;
    logic signed [ERR_W-1:0] row_error;
    steer_t                  steer_q[$];
    int                      fail_count = 0;
    int                      checked_count = 0;

    function automatic logic signed [ERR_W-1:0] clip_error(longint v);
        if (v > ERR_MAX) return ERR_MAX[ERR_W-1:0];
        if (v < ERR_MIN) return ERR_MIN[ERR_W-1:0];
        return v[ERR_W-1:0];
    endfunction

    function automatic logic signed [SPEED_W-1:0] clip_speed(longint v);
        if (v > SPEED_MAX) return SPEED_MAX[SPEED_W-1:0];
        if (v < SPEED_MIN) return SPEED_MIN[SPEED_W-1:0];
        return v[SPEED_W-1:0];
    endfunction

    // Base speed minus magnitude times gain, in Q24, cut toward zero.
    function automatic logic signed [SPEED_W-1:0] slowed_speed(longint unsigned mag);
        longint full;
        longint whole;
        full = (longint'(regs.base_speed) <<< FRAC_W) - longint'(mag * longint'(regs.steer_gain));
        whole = (full >= 0) ? (full >>> FRAC_W) : -((-full) >>> FRAC_W);
        return clip_speed(whole);
    endfunction

    function automatic void track_pixel(logic [LUM_W-1:0] lum, logic row_end);
        logic [ROW_W-1:0]    span;
        logic [HALF_W-1:0]   mid;
        logic [WEIGHT_W-1:0] weight;
        longint              term;
        steer_t              want;
        span = regs.row_width;
        if (span < ROW_W'(2)) span = ROW_W'(2);
        else if (span > ROW_W'(MAX_ROW_WIDTH)) span = ROW_W'(MAX_ROW_WIDTH);
        mid = HALF_W'(span / 2);
        // The centre column is neutral; either side uses its own weight.
        if (lum > regs.lum_threshold && column != mid) begin
            weight = (column > mid) ? regs.right_weight : regs.left_weight;
            term = longint'(column) * longint'(weight) - longint'(mid) * 256;
            row_error = clip_error(longint'(row_error) + term);
        end
        if (column != {COL_W{1'b1}}) column = column + 1'b1;
        if (row_end) begin
            want.line_error  = row_error;
            want.left_speed  = SPEED_W'(regs.base_speed);
            want.right_speed = SPEED_W'(regs.base_speed);
            if (row_error > 0) want.right_speed = slowed_speed(longint'(row_error));
            else if (row_error < 0) want.left_speed = slowed_speed(-longint'(row_error));
            steer_q.push_back(want);
            column = '0;
            row_error = '0;
        end
    endfunction

    always @(posedge aclk) begin : watch
        steer_t got;
        steer_t want;
        if (!aresetn) begin
            regs = '{base_speed: RST_BASE_SPEED, steer_gain: RST_STEER_GAIN,
                     lum_threshold: RST_LUM_THRESHOLD, right_weight: RST_RIGHT_WEIGHT,
                     left_weight: RST_LEFT_WEIGHT, row_width: RST_ROW_WIDTH};
            column = '0;
            row_error = '0;
            steer_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASE_SPEED:    regs.base_speed    = cfg_data[BASE_W-1:0];
                    REG_STEER_GAIN:    regs.steer_gain    = cfg_data[GAIN_W-1:0];
                    REG_LUM_THRESHOLD: regs.lum_threshold = cfg_data[LUM_W-1:0];
                    REG_RIGHT_WEIGHT:  regs.right_weight  = cfg_data[WEIGHT_W-1:0];
                    REG_LEFT_WEIGHT:   regs.left_weight   = cfg_data[WEIGHT_W-1:0];
                    REG_ROW_WIDTH:     regs.row_width     = cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) track_pixel(s_tdata[LUM_W-1:0], s_tlast);
            if (m_tvalid && m_tready) begin
                got = steer_t'(m_tdata);
                if (steer_q.size() == 0) begin
                    $display("%0t: result item with no row pending: error %0d left %0d right %0d",
                             $time, got.line_error, got.left_speed, got.right_speed);
                    fail_count++;
                end else begin
                    want = steer_q.pop_front();
                    checked_count++;
                    if (got.line_error !== want.line_error) begin
                        $display("%0t: row %0d line_error expected %0d, got %0d",
                                 $time, checked_count, want.line_error, got.line_error);
                        fail_count++;
                    end
                    if (got.left_speed !== want.left_speed) begin
                        $display("%0t: row %0d left_speed expected %0d, got %0d",
                                 $time, checked_count, want.left_speed, got.left_speed);
                        fail_count++;
                    end
                    if (got.right_speed !== want.right_speed) begin
                        $display("%0t: row %0d right_speed expected %0d, got %0d",
                                 $time, checked_count, want.right_speed, got.right_speed);
                        fail_count++;
                    end
                end
            end
        end
        rows_pending <= steer_q.size();
        rows_checked <= checked_count;
        mismatches   <= fail_count;
    end

endmodule

// ===== tb/line_follow_steering_tb.sv =====
// Testbench top: drives pixel rows and register settings and gives the verdict.
`timescale 1ns / 1ps

module line_follow_steering_tb;
    import lfs_pkg::*;

    // A row-end item reaches its result through the input, term, error, product and output
    // registers; settle a bit longer than that pass before touching the registers.
    localparam int SETTLE_CYCLES   = 8;
    // The slowest legal run stays well under this limit, so it only trips on a hang.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PIXELS   = 980;
    localparam int MIN_RANDOM_ROWS = 48;

    // Indexes the block does not decode; writes to them must leave every register alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int rows_pending;
    int rows_checked;
    int mismatches;
    int cycles = 0;
    int src_calm = 0;
    int sink_calm = 0;
    int pixels_sent = 0;
    int rows_sent = 0;
    int settings_loaded = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_follow_steering DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_follow_steering_checker steer_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rows_pending (rows_pending),
        .rows_checked (rows_checked),
        .mismatches   (mismatches)
    );

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d rows outstanding.",
                     cycles, rows_pending);
            $display("line_follow_steering_tb: FAIL");
            $finish;
        end
    end

    // Number of idle cycles before the next item on one side. Now and then a calm
    // stretch starts, during which that side runs at full rate.
    function automatic int next_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Random register value: often an extreme, sometimes with junk above the
    // register's width that the block has to drop.
    function automatic logic [CFG_DATA_W-1:0] pick_value(int bits);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] v;
        mask = (CFG_DATA_W'(1) << bits) - 1'b1;
        case ($urandom_range(0, 4))
            0: v = '0;
            1: v = mask;
            default: v = CFG_DATA_W'($urandom) & mask;
        endcase
        if ($urandom_range(0, 3) == 0) v = v | (CFG_DATA_W'($urandom) & ~mask);
        return v;
    endfunction

    // Row widths stay small most of the time so that rows end often; the
    // out-of-range values and large widths still show up.
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 19))
            0:       v = CFG_DATA_W'($urandom_range(0, 1));
            1:       v = CFG_DATA_W'($urandom_range(MAX_ROW_WIDTH + 1, 8191));
            2:       v = CFG_DATA_W'($urandom_range(25, MAX_ROW_WIDTH));
            default: v = CFG_DATA_W'($urandom_range(2, 24));
        endcase
        if ($urandom_range(0, 3) == 0) v[CFG_DATA_W-1:ROW_W] = (CFG_DATA_W-ROW_W)'($urandom);
        return v;
    endfunction

    // One pixel item. While valid is low the data lines carry junk.
    task automatic send_pixel(input logic [LUM_W-1:0] lum, input logic row_end);
        int gap;
        gap = next_wait(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lum;
        s_tlast  <= row_end;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        if (row_end) rows_sent++;
    endtask

    // A row of len pixels. Most rows look like a camera line: a short bright band
    // above the threshold on a dark background. The rest are plain noise.
    task automatic send_row(input int len, input int cutoff);
        int              band_lo;
        int              band_hi;
        bit              lined;
        logic [LUM_W-1:0] lum;
        lined   = ($urandom_range(0, 9) < 7);
        band_lo = $urandom_range(0, len - 1);
        band_hi = band_lo + $urandom_range(0, 4);
        for (int c = 0; c < len; c++) begin
            if (!lined) lum = LUM_W'($urandom);
            else if (c >= band_lo && c <= band_hi)
                lum = (cutoff >= 255) ? 8'hFF : LUM_W'($urandom_range(cutoff + 1, 255));
            else lum = LUM_W'($urandom_range(0, cutoff));
            send_pixel(lum, c == len - 1);
        end
    endtask

    // Let every pending result come back, then give the pipeline time to empty,
    // since pixels without a row end leave no result to wait for.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rows_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes all six registers back to back; with spare set, the undecoded indexes
    // are written in between.
    task automatic set_regs(input logic [CFG_DATA_W-1:0] base, gain, thr, rw, lw, width,
                            input bit spare);
        write_reg(REG_BASE_SPEED, base);
        if (spare) write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_STEER_GAIN, gain);
        write_reg(REG_LUM_THRESHOLD, thr);
        write_reg(REG_RIGHT_WEIGHT, rw);
        if (spare) write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        write_reg(REG_LEFT_WEIGHT, lw);
        write_reg(REG_ROW_WIDTH, width);
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IDX_W'($urandom);
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        settings_loaded++;
    endtask

    // Result side: stalls a random number of cycles before each item, with
    // stretches where it is always ready.
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            stall = next_wait(sink_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] base;
        logic [CFG_DATA_W-1:0] gain;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] rw;
        logic [CFG_DATA_W-1:0] lw;
        logic [CFG_DATA_W-1:0] width;
        int                    span;
        int                    len;
        int                    random_pixels;
        int                    random_rows;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings (320-pixel row, threshold 250). Each of these rows ends on
        // its first pixel, so column 0 is far left of centre. A pixel equal to the
        // threshold does not count; one above it does.
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd250, 1'b1);
        send_pixel(8'd251, 1'b1);
        drain();

        // Largest gain, speed and weights on an 8-pixel row. The fifth pixel sits on
        // the centre column and must add nothing; 127 and 128 straddle the threshold.
        set_regs(16'd1023, 16'hFFFF, 16'd127, 16'd1023, 16'd1023, 16'd8, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain();

        // Threshold at its top: nothing counts, so the error is zero and both speeds
        // stay at base. Width 0 is taken as 2.
        set_regs(16'd0, 16'd0, 16'd255, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain();

        // Threshold 0 with width 1 (taken as 2): the row runs past its width.
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain();

        // Widest register value, clamped to the largest row.
        set_regs(16'd1023, 16'hFFFF, 16'd0, 16'd1023, 16'd1023, 16'h1FFF, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain();

        // Smallest row with both sides weighted: the right-hand pixel wins.
        set_regs(16'd1023, 16'hFFFF, 16'd0, 16'd1023, 16'd1023, 16'd2, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b1);
        drain();

        // Random settings, each followed by a handful of rows. Most rows match the
        // width; the others are cut short or run long.
        random_pixels = 0;
        random_rows   = 0;
        while (random_pixels < RANDOM_PIXELS || random_rows < MIN_RANDOM_ROWS) begin
            base  = pick_value(BASE_W);
            gain  = ($urandom_range(0, 1) == 0) ? pick_value(GAIN_W)
                                                : CFG_DATA_W'($urandom_range(0, 4095));
            thr   = pick_value(LUM_W);
            rw    = pick_value(WEIGHT_W);
            lw    = pick_value(WEIGHT_W);
            width = pick_width();
            set_regs(base, gain, thr, rw, lw, width, $urandom_range(0, 3) == 0);
            span = int'(width[ROW_W-1:0]);
            if (span < 2) span = 2;
            else if (span > MAX_ROW_WIDTH) span = MAX_ROW_WIDTH;
            repeat ($urandom_range(3, 12)) begin
                if (span <= 32 && $urandom_range(0, 3) != 0) len = span;
                else len = $urandom_range(1, 40);
                send_row(len, int'(thr[LUM_W-1:0]));
                random_pixels += len;
                random_rows++;
            end
            drain();
        end

        $display("Drove %0d pixel items in %0d rows over %0d register settings,",
                 pixels_sent, rows_sent, settings_loaded);
        $display("with clamped widths, saturated speeds and short or long rows; %0d compared.",
                 rows_checked);
        if (mismatches == 0) begin
            $display("line_follow_steering_tb: PASS");
        end else begin
            $display("line_follow_steering_tb: FAIL");
        end
        $finish;
    end

endmodule
